/* rtl/assert_macros.svh */
// Assertion macros for the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CSVT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define CSVT_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* rtl/csvt_pkg.sv */
// Types and constants of the CSV line tokenizer.
package csvt_pkg;

    localparam int MAX_FIELDS = 255;
    localparam int FIELD_CAP_INT = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;
    localparam logic [7:0] FIELD_CAP = 8'(FIELD_CAP_INT);
    localparam logic [7:0] DELIM_RESET = 8'd44;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } csvt_in_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       field_end;
        logic       record_end;
        logic       input_done;
        logic [7:0] field_number;
    } csvt_out_t;

    // Result of one step: whether a word goes out, and that word.
    typedef struct packed {
        logic      emit;
        csvt_out_t word;
    } csvt_step_res_t;

endpackage

/* rtl/csvt_step.sv */
// Parse state and per-byte transition logic of the tokenizer.
`include "assert_macros.svh"

module csvt_step
    import csvt_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  csvt_in_t       word,
    input  logic [7:0]     delimiter,
    output csvt_step_res_t res
);

    localparam logic [2:0] ST_DELIM  = 3'd0;
    localparam logic [2:0] ST_QUOTED = 3'd1;
    localparam logic [2:0] ST_QUOTE1 = 3'd2;
    localparam logic [2:0] ST_QESC   = 3'd3;
    localparam logic [2:0] ST_SIMPLE = 3'd4;
    localparam logic [2:0] ST_SESC   = 3'd5;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_TAB   = 8'h09;

    logic [2:0] state_reg, state_next;
    logic       open_reg, open_next;
    logic [7:0] count_reg, count_next;

    logic [2:0] st;
    logic [7:0] c;
    logic [7:0] esc_byte;
    logic       do_end;
    logic       do_next;
    logic       emit;
    logic       has;
    logic [7:0] obyte;
    logic       fend;
    logic       rend;
    logic       done;

    assign c = word.in_byte;

    always_comb
    begin
        if (c == CH_N)
        begin
            esc_byte = CH_LF;
        end
        else if (c == CH_T)
        begin
            esc_byte = CH_TAB;
        end
        else
        begin
            esc_byte = c;
        end
    end

    // Unused codes behave as between fields.
    assign st = (state_reg > ST_SESC) ? ST_DELIM : state_reg;

    always_comb
    begin
        state_next = state_reg;
        open_next  = open_reg;
        do_end     = 1'b0;
        do_next    = 1'b0;
        emit       = 1'b0;
        has        = 1'b0;
        obyte      = c;
        fend       = 1'b0;
        rend       = 1'b0;
        done       = 1'b0;

        if (word.end_of_input)
        begin
            emit   = 1'b1;
            done   = 1'b1;
            do_end = 1'b1;
            fend   = (st != ST_DELIM);
            rend   = (st != ST_DELIM) || open_reg;
        end
        else
        begin
            unique case (st)
                ST_QUOTED:
                begin
                    priority if (c == CH_QUOTE)
                    begin
                        state_next = ST_QUOTE1;
                    end
                    else if (c == CH_BSL)
                    begin
                        state_next = ST_QESC;
                    end
                    else
                    begin
                        emit = 1'b1;
                        has  = 1'b1;
                    end
                end
                ST_QUOTE1:
                begin
                    priority if (c == CH_LF)
                    begin
                        emit   = 1'b1;
                        fend   = 1'b1;
                        rend   = 1'b1;
                        do_end = 1'b1;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        state_next = ST_QUOTED;
                        emit       = 1'b1;
                        has        = 1'b1;
                    end
                    else if (c == CH_CR)
                    begin
                        state_next = ST_SIMPLE;
                    end
                    else if (c == delimiter)
                    begin
                        emit    = 1'b1;
                        fend    = 1'b1;
                        do_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SIMPLE;
                        emit       = 1'b1;
                        has        = 1'b1;
                    end
                end
                ST_QESC:
                begin
                    state_next = ST_QUOTED;
                    emit       = 1'b1;
                    has        = 1'b1;
                    obyte      = esc_byte;
                end
                ST_SESC:
                begin
                    state_next = ST_SIMPLE;
                    emit       = 1'b1;
                    has        = 1'b1;
                    obyte      = esc_byte;
                end
                ST_SIMPLE:
                begin
                    priority if (c == CH_LF)
                    begin
                        emit   = 1'b1;
                        fend   = 1'b1;
                        rend   = 1'b1;
                        do_end = 1'b1;
                    end
                    else if (c == CH_CR)
                    begin
                        state_next = ST_SIMPLE;
                    end
                    else if (c == CH_BSL)
                    begin
                        state_next = ST_SESC;
                    end
                    else if (c == delimiter)
                    begin
                        emit    = 1'b1;
                        fend    = 1'b1;
                        do_next = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        has  = 1'b1;
                    end
                end
                default:
                begin
                    priority if (c == CH_LF)
                    begin
                        emit   = 1'b1;
                        fend   = 1'b1;
                        rend   = 1'b1;
                        do_end = 1'b1;
                    end
                    else if (c == CH_CR)
                    begin
                        state_next = ST_DELIM;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        state_next = ST_QUOTED;
                        open_next  = 1'b1;
                    end
                    else if (c == CH_BSL)
                    begin
                        state_next = ST_SESC;
                        open_next  = 1'b1;
                    end
                    else if (c == delimiter)
                    begin
                        emit    = 1'b1;
                        fend    = 1'b1;
                        do_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SIMPLE;
                        open_next  = 1'b1;
                        emit       = 1'b1;
                        has        = 1'b1;
                    end
                end
            endcase
        end

        count_next = count_reg;
        if (do_end)
        begin
            state_next = ST_DELIM;
            open_next  = 1'b0;
            count_next = 8'd0;
        end
        else if (do_next)
        begin
            state_next = ST_DELIM;
            open_next  = 1'b1;
            if (count_reg < FIELD_CAP)
            begin
                count_next = count_reg + 8'd1;
            end
        end
    end

    always_comb
    begin
        res.emit              = emit;
        res.word.has_byte     = has;
        res.word.out_byte     = has ? obyte : 8'd0;
        res.word.field_end    = fend;
        res.word.record_end   = rend;
        res.word.input_done   = done;
        res.word.field_number = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DELIM;
            open_reg  <= 1'b0;
            count_reg <= 8'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            count_reg <= count_next;
        end
    end

    `CSVT_ASSERT_ALWAYS(a_count_cap, count_reg <= FIELD_CAP, "field count above cap")
    `CSVT_ASSERT_ALWAYS(a_count_open, (count_reg == 8'd0) || open_reg, "fields counted with no record open")
    `CSVT_ASSERT_NEXT(a_eoi_clears, advance && word.end_of_input, (state_reg == ST_DELIM) && !open_reg && (count_reg == 8'd0), "state not cleared after end of input")

endmodule

/* rtl/csv_line_tokenizer.sv */
// Top level of the CSV line tokenizer: input register, step logic, result register.
// Bytes wait in the input register, result words in the result register. One byte
// per cycle unless the output stalls; the input register feeds one step of the
// parse state machine in csvt_step, and the result register decouples the output
// side. Bytes that only change state (quotes, backslash, CR) yield no result word.
// Reset (rst_n low, asynchronous): pipeline empty, parse state between fields,
// no record open, field count zero, delimiter back to comma.
module csv_line_tokenizer
    import csvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input bytes
    input  logic       item_valid,
    output logic       item_ready,
    input  csvt_in_t   item,
    // result words
    output logic       result_valid,
    input  logic       result_ready,
    output csvt_out_t  result,
    // delimiter write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    // Input register stage.
    logic           s1_valid_reg;
    csvt_in_t       s1_word_reg;
    logic           s1_fire;

    // Result register stage.
    logic           out_valid_reg;
    csvt_out_t      out_word_reg;

    logic [7:0]     delim_reg;
    csvt_step_res_t step_res;

    // The staged byte steps the parser whenever the result register is free
    // or being drained this cycle, whether or not it yields a word.
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_fire;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
        end
        else if (cfg_valid)
        begin
            delim_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_word_reg <= item;
        end
    end

    csvt_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_fire),
        .word      (s1_word_reg),
        .delimiter (delim_reg),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= step_res.emit;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && step_res.emit)
        begin
            out_word_reg <= step_res.word;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule
